// File: rtl/mss_pkg.sv
// Shared types and constants for the multi-stack shared store.
package mss_pkg;

   localparam int SID_W = 2;
   localparam int VAL_W = 32;
   localparam int STATUS_W = 2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dpath_status_type;

endpackage

// File: rtl/mss_if.sv
// Request and response channel interfaces of the multi-stack shared store.
interface mss_req_if
   import mss_pkg::*;
();
   logic valid;
   logic ready;
   logic req_type;
   logic [SID_W-1:0] stack_id;
   logic signed [VAL_W-1:0] push_value;

   modport source(output valid, output req_type, output stack_id, output push_value,
                  input ready);
   modport sink(input valid, input req_type, input stack_id, input push_value,
                output ready);
endinterface

interface mss_rsp_if
   import mss_pkg::*;
();
   logic valid;
   logic ready;
   logic signed [VAL_W-1:0] pop_value;
   logic [STATUS_W-1:0] status;

   modport source(output valid, output pop_value, output status, input ready);
   modport sink(input valid, input pop_value, input status, output ready);
endinterface

// File: rtl/mss_ctrl.sv
// Controller state machine that sequences the read and write phases of an item.
module mss_ctrl
   import mss_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dpath_status_type dp_status,
   output ctrl_cmd_type     cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (dp_status.out_free) begin
               cmd.execute = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/mss_dpath.sv
// Datapath with the slot memories, stack heads, free list and result register.
module mss_dpath
   import mss_pkg::*;
#(
   parameter int NUM_STACKS = 4,
   parameter int CAPACITY = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_cmd_type            cmd,
   output dpath_status_type        dp_status,
   input  logic                    req_type,
   input  logic [SID_W-1:0]        stack_id,
   input  logic signed [VAL_W-1:0] push_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] pop_value,
   output logic [STATUS_W-1:0]     status
);

   localparam int LW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int IW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int XW = (IW > SID_W) ? IW : SID_W;
   localparam logic [LW-1:0] LINK_NULL = LW'(CAPACITY);
   localparam logic [LW-1:0] LAST_SLOT = LW'(CAPACITY - 1);

   logic [VAL_W-1:0] values_mem [CAPACITY];
   logic [LW-1:0]    links_mem [CAPACITY];

   logic [LW-1:0] heads_ff [NUM_STACKS];
   logic [LW-1:0] free_ff;
   logic [LW-1:0] fill_ff;

   logic             op_ff;
   logic [IW-1:0]    sid_ff;
   logic [VAL_W-1:0] val_ff;
   logic [LW-1:0]    slot_ff;
   logic             refused_ff;
   logic [LW-1:0]    link_rd_ff;
   logic [VAL_W-1:0] value_rd_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic signed [VAL_W-1:0] pop_value_ff;
   logic [STATUS_W-1:0]     status_ff;

   logic [XW-1:0] sid_x;
   logic [IW-1:0] sid_idx;
   logic          sid_ok;
   logic [LW-1:0] slot_in;
   logic          refused_in;
   logic [LW-1:0] seq_link;
   logic [LW-1:0] next_free;
   logic          do_push;
   logic          do_pop;

   assign sid_x = XW'(stack_id);
   assign sid_idx = sid_x[IW-1:0];
   assign sid_ok = 32'(stack_id) < 32'(NUM_STACKS);

   always_comb begin
      if (req_type == OP_POP) begin
         slot_in = heads_ff[sid_idx];
      end else begin
         slot_in = free_ff;
      end
      refused_in = !sid_ok || (slot_in >= LINK_NULL);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_type;
         sid_ff <= sid_idx;
         val_ff <= push_value;
         slot_ff <= slot_in;
         refused_ff <= refused_in;
         link_rd_ff <= links_mem[slot_in[AW-1:0]];
         value_rd_ff <= values_mem[slot_in[AW-1:0]];
      end
   end

   // Slots at or above the fill mark were never taken and still link to the next slot.
   assign seq_link = (slot_ff == LAST_SLOT) ? LINK_NULL : slot_ff + LW'(1);
   assign next_free = (slot_ff >= fill_ff) ? seq_link : link_rd_ff;
   assign do_push = cmd.execute && !refused_ff && (op_ff == OP_PUSH);
   assign do_pop = cmd.execute && !refused_ff && (op_ff == OP_POP);

   always_ff @(posedge clock) begin
      if (do_push) begin
         values_mem[slot_ff[AW-1:0]] <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         links_mem[slot_ff[AW-1:0]] <= heads_ff[sid_ff];
      end else if (do_pop) begin
         links_mem[slot_ff[AW-1:0]] <= free_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STACKS; i++) begin
            heads_ff[i] <= LINK_NULL;
         end
         free_ff <= '0;
         fill_ff <= '0;
      end else if (do_push) begin
         heads_ff[sid_ff] <= slot_ff;
         free_ff <= next_free;
         if (slot_ff == fill_ff) begin
            fill_ff <= fill_ff + LW'(1);
         end
      end else if (do_pop) begin
         heads_ff[sid_ff] <= link_rd_ff;
         free_ff <= slot_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         pop_value_ff <= do_pop ? value_rd_ff : '0;
         if (!refused_ff) begin
            status_ff <= STATUS_DONE;
         end else if (op_ff == OP_PUSH) begin
            status_ff <= STATUS_FULL;
         end else begin
            status_ff <= STATUS_EMPTY;
         end
      end
   end

   assign dp_status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign pop_value = pop_value_ff;
   assign status = status_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LINK_NULL)
      else $error("fill mark beyond capacity");

   a_pop_from_taken_slot: assert property (@(posedge clock) disable iff (reset)
      do_pop |-> slot_ff < fill_ff)
      else $error("pop from a slot that was never taken");

   a_result_after_execute: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.execute))
      else $error("result appeared without an executed item");

   a_push_advances_free: assert property (@(posedge clock) disable iff (reset)
      do_push |=> free_ff != $past(slot_ff))
      else $error("pushed slot still heads the free list");

endmodule

// File: rtl/multi_stack_shared_store_top.sv
// Top level of the multi-stack shared store.
// NUM_STACKS LIFO stacks share CAPACITY slots of one value and link memory; free
// slots sit on a free list and never-used slots are handed out in order by a fill
// mark, so the block needs no clearing pass after reset. An item has two phases:
// a read of the addressed slot from the synchronous memories, then a write of links,
// heads and the free list back and a load of the result register. The next item is taken
// while a result waits; the write phase waits only while the result register is full.
// A push onto a full store answers status 1, a pop from an empty stack status 2 with
// value zero; stack numbers at or above NUM_STACKS are refused the same way.
module multi_stack_shared_store_top
   import mss_pkg::*;
#(
   parameter int NUM_STACKS = 4,
   parameter int CAPACITY = 16
) (
   input logic      clock,
   input logic      reset,
   mss_req_if.sink  req_ch,
   mss_rsp_if.source rsp_ch
);

   ctrl_cmd_type     cmd;
   dpath_status_type dp_status;

   mss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   mss_dpath #(
      .NUM_STACKS (NUM_STACKS),
      .CAPACITY   (CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .dp_status  (dp_status),
      .req_type   (req_ch.req_type),
      .stack_id   (req_ch.stack_id),
      .push_value (req_ch.push_value),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .pop_value  (rsp_ch.pop_value),
      .status     (rsp_ch.status)
   );

endmodule

// File: sim/multi_stack_shared_store_top_tb.sv
// Testbench for the multi-stack shared store: directed table and random push/pop traffic.
module multi_stack_shared_store_top_tb
   import mss_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSTK = 4;
   localparam int CAP = 16;
   localparam logic [4:0] NULL_LINK = 5'(CAP);
   localparam int RANDOM_ITEMS = 1400;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      status_type status;
   } stack_answer_type;

   typedef struct packed {
      logic op;
      logic [SID_W-1:0] sid;
      logic [VAL_W-1:0] value;
      logic typed;
      logic [VAL_W-1:0] exp_value;
      status_type exp_status;
   } dir_row_type;

   localparam int DIR_ROWS = 25;

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{OP_POP, 2'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_EMPTY},
      '{OP_POP, 2'd1, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STATUS_EMPTY},
      '{OP_POP, 2'd2, 32'h1234_5678, 1'b1, 32'h0000_0000, STATUS_EMPTY},
      '{OP_POP, 2'd3, 32'h8000_0000, 1'b1, 32'h0000_0000, STATUS_EMPTY},
      '{OP_PUSH, 2'd0, 32'h8000_0000, 1'b1, 32'h0000_0000, STATUS_DONE},
      '{OP_PUSH, 2'd3, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, STATUS_DONE},
      '{OP_POP, 2'd3, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, STATUS_DONE},
      '{OP_POP, 2'd0, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, STATUS_DONE},
      '{OP_PUSH, 2'd0, 32'hFFFF_FFFF, 1'b0, 32'h0, STATUS_DONE},
      '{OP_PUSH, 2'd1, 32'h0000_0000, 1'b0, 32'h0, STATUS_DONE},
      '{OP_PUSH, 2'd2, 32'h0000_0001, 1'b0, 32'h0, STATUS_DONE},
      '{OP_PUSH, 2'd3, 32'hFFFF_FFFE, 1'b0, 32'h0, STATUS_DONE},
      '{OP_PUSH, 2'd0, 32'h5555_5555, 1'b0, 32'h0, STATUS_DONE},
      '{OP_PUSH, 2'd0, 32'hAAAA_AAAA, 1'b0, 32'h0, STATUS_DONE},
      '{OP_PUSH, 2'd1, 32'h8000_0001, 1'b0, 32'h0, STATUS_DONE},
      '{OP_PUSH, 2'd1, 32'h7FFF_FFFE, 1'b0, 32'h0, STATUS_DONE},
      '{OP_PUSH, 2'd2, 32'h0F0F_0F0F, 1'b0, 32'h0, STATUS_DONE},
      '{OP_PUSH, 2'd2, 32'hF0F0_F0F0, 1'b0, 32'h0, STATUS_DONE},
      '{OP_PUSH, 2'd3, 32'h0000_FFFF, 1'b0, 32'h0, STATUS_DONE},
      '{OP_PUSH, 2'd3, 32'hFFFF_0000, 1'b0, 32'h0, STATUS_DONE},
      '{OP_PUSH, 2'd0, 32'h0000_0010, 1'b0, 32'h0, STATUS_DONE},
      '{OP_PUSH, 2'd1, 32'h0000_0020, 1'b0, 32'h0, STATUS_DONE},
      '{OP_PUSH, 2'd2, 32'h0000_0030, 1'b0, 32'h0, STATUS_DONE},
      '{OP_PUSH, 2'd3, 32'h0000_0040, 1'b0, 32'h0, STATUS_DONE},
      '{OP_PUSH, 2'd2, 32'h0BAD_CAFE, 1'b1, 32'h0000_0000, STATUS_FULL}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   int errors = 0;
   int cycle_count = 0;
   bit no_idle = 1'b0;

   logic [VAL_W-1:0] slot_data [CAP];
   logic [4:0] slot_next [CAP];
   logic [4:0] top_slot [NSTK];
   logic [4:0] free_slot;
   stack_answer_type pending_answers [$];

   mss_req_if req_ch ();
   mss_rsp_if rsp_ch ();

   multi_stack_shared_store_top #(
      .NUM_STACKS(NSTK),
      .CAPACITY(CAP)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[multi_stack_shared_store_top] ERROR");
         $finish;
      end
   end

   function automatic stack_answer_type apply_stack_op(input logic op,
                                                       input logic [SID_W-1:0] sid,
                                                       input logic [VAL_W-1:0] val);
      stack_answer_type ans;
      logic [4:0] slot;
      ans.value = '0;
      ans.status = STATUS_DONE;
      if (op == OP_PUSH) begin
         if (int'(sid) >= NSTK || free_slot >= NULL_LINK) begin
            ans.status = STATUS_FULL;
         end else begin
            slot = free_slot;
            free_slot = slot_next[slot];
            slot_data[slot] = val;
            slot_next[slot] = top_slot[sid];
            top_slot[sid] = slot;
         end
      end else begin
         if (int'(sid) >= NSTK || top_slot[sid] >= NULL_LINK) begin
            ans.status = STATUS_EMPTY;
         end else begin
            slot = top_slot[sid];
            top_slot[sid] = slot_next[slot];
            ans.value = slot_data[slot];
            slot_next[slot] = free_slot;
            free_slot = slot;
         end
      end
      return ans;
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic issue(input logic op, input logic [SID_W-1:0] sid,
                        input logic [VAL_W-1:0] val, input logic typed,
                        input stack_answer_type typed_ans);
      int gap;
      stack_answer_type predicted;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.req_type = op;
      req_ch.stack_id = sid;
      req_ch.push_value = val;
      do @(posedge clock); while (!req_ch.ready);
      predicted = apply_stack_op(op, sid, val);
      pending_answers.push_back(typed ? typed_ans : predicted);
      @(negedge clock);
   endtask

   task automatic drain_answers();
      req_ch.valid = 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
   endtask

   initial begin
      int stall;
      stack_answer_type exp_ans;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (pending_answers.size() == 0) begin
            $error("unexpected result: pop_value %08h status %0d", rsp_ch.pop_value,
                   rsp_ch.status);
            errors++;
         end else begin
            exp_ans = pending_answers.pop_front();
            if (rsp_ch.pop_value !== exp_ans.value) begin
               $error("pop_value: expected %08h, got %08h", exp_ans.value, rsp_ch.pop_value);
               errors++;
            end
            if (rsp_ch.status !== exp_ans.status) begin
               $error("status: expected %0d, got %0d", exp_ans.status, rsp_ch.status);
               errors++;
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      int push_pct;
      int focus;
      logic op;
      logic [SID_W-1:0] sid;
      logic [VAL_W-1:0] val;
      req_ch.valid = 1'b0;
      req_ch.req_type = OP_PUSH;
      req_ch.stack_id = '0;
      req_ch.push_value = '0;
      for (int i = 0; i < CAP; i++) begin
         slot_data[i] = '0;
         slot_next[i] = 5'(i + 1);
      end
      for (int i = 0; i < NSTK; i++) top_slot[i] = NULL_LINK;
      free_slot = '0;
      push_pct = 50;
      focus = NSTK;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         issue(dir_rows[i].op, dir_rows[i].sid, dir_rows[i].value, dir_rows[i].typed,
               '{value: dir_rows[i].exp_value, status: dir_rows[i].exp_status});
      end
      drain_answers();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) begin
            case ($urandom_range(0, 3))
               0: push_pct = 10;
               1: push_pct = 50;
               2: push_pct = 85;
               default: push_pct = 97;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            focus = $urandom_range(0, NSTK);
         end
         if (n == RANDOM_ITEMS / 2) drain_answers();
         op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
         sid = (focus < NSTK && $urandom_range(0, 1) == 1) ? SID_W'(focus)
                                                            : SID_W'($urandom_range(0, 3));
         case ($urandom_range(0, 7))
            0: val = 32'h8000_0000;
            1: val = 32'h7FFF_FFFF;
            2: val = 32'(-$urandom_range(1, 16));
            3: val = 32'($urandom_range(0, 16));
            default: val = $urandom();
         endcase
         issue(op, sid, val, 1'b0, '{value: '0, status: STATUS_DONE});
      end

      no_idle = 1'b0;
      req_ch.valid = 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("[multi_stack_shared_store_top] OK");
      end else begin
         $display("[multi_stack_shared_store_top] ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/mss_pkg.sv
rtl/mss_if.sv
rtl/mss_ctrl.sv
rtl/mss_dpath.sv
rtl/multi_stack_shared_store_top.sv
sim/multi_stack_shared_store_top_tb.sv
